[hw/rtl/bto2d_pkg.sv]
`default_nettype none

package bto2d_pkg;

    // slope class of one triangle edge
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_RISE,
        CLS_FALL,
        CLS_VERT,
        CLS_HORZ
    } t_cls;

    // sign of a value: neither bit set means zero
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sgn;

    // position of each orientation within one edge's group
    localparam int unsigned Q_THIRD = 0;
    localparam int unsigned Q_CRN0  = 1;
    localparam int unsigned Q_CRN1  = 2;

    // separation rule for one edge given the three orientations
    function automatic logic edge_sep(input t_cls cls, input t_sgn o,
                                      input t_sgn o0, input t_sgn o1);
        logic o_zero;
        logic res;
        o_zero = !o.pos && !o.neg;
        if (cls == CLS_NONE) begin
            res = 1'b0;
        end else if (o_zero) begin
            // third vertex on the line: both corners strictly on one side
            res = (o0.pos && o1.pos) || (o0.neg && o1.neg);
        end else begin
            // both corners strictly opposite the third vertex
            res = (o.pos && o0.neg && o1.neg) || (o.neg && o0.pos && o1.pos);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/box_triangle_overlap_2d_core.sv]
// Box / triangle overlap test in 2d, separating-axis style.
// Input channel: i_valid with the box bounds and three triangle vertices,
// o_stall back to the sender; a request is taken on a clock edge where
// i_valid is high and o_stall is low.
// Output channel: o_valid with o_overlap, i_stall from the receiver; a
// result is taken where o_valid is high and i_stall is low.
// o_overlap is 1 when the pair may intersect and 0 when some box side or
// triangle edge separates them. Orientations are exact integer products.
// Four register stages: edge differences and box rejects, the products,
// the orientation signs, the final verdict. One request is taken every
// cycle while the receiver keeps up.
// Each stage holds its data only while the stage after it is full and
// stalled, so bubbles close up and a stall at the output reaches o_stall
// only once the whole pipe is full. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties all stages; no result is shown
// until new requests arrive.
`default_nettype none

module box_triangle_overlap_2d_core
    import bto2d_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_x,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_y,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_x,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_y,
    input  wire logic signed [COORD_BITS-1:0] i_vert_a_x,
    input  wire logic signed [COORD_BITS-1:0] i_vert_a_y,
    input  wire logic signed [COORD_BITS-1:0] i_vert_b_x,
    input  wire logic signed [COORD_BITS-1:0] i_vert_b_y,
    input  wire logic signed [COORD_BITS-1:0] i_vert_c_x,
    input  wire logic signed [COORD_BITS-1:0] i_vert_c_y,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_overlap
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int OW = PW + 1;

    // sign of a coordinate difference
    function automatic t_sgn sgn_d(input logic signed [DW-1:0] v);
        t_sgn s;
        s.neg = v[DW-1];
        s.pos = !v[DW-1] && (|v);
        return s;
    endfunction

    // sign of a product difference
    function automatic t_sgn sgn_o(input logic signed [OW-1:0] v);
        t_sgn s;
        s.neg = v[OW-1];
        s.pos = !v[OW-1] && (|v);
        return s;
    endfunction

    // stage enables: a stage loads when empty or when the next one moves
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3, en4;

    assign en4     = !o_valid || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (en1) r_v1    <= i_valid;
            if (en2) r_v2    <= r_v1;
            if (en3) r_v3    <= r_v2;
            if (en4) o_valid <= r_v3;
        end
    end

    // vertex views for edge indexing
    logic signed [COORD_BITS-1:0] vx [3];
    logic signed [COORD_BITS-1:0] vy [3];

    assign vx[0] = i_vert_a_x;
    assign vy[0] = i_vert_a_y;
    assign vx[1] = i_vert_b_x;
    assign vy[1] = i_vert_b_y;
    assign vx[2] = i_vert_c_x;
    assign vy[2] = i_vert_c_y;

    // stage 1: box side rejects
    logic r1_rej, n1_rej;

    always_comb begin
        n1_rej = (i_vert_a_x <= i_box_min_x && i_vert_b_x <= i_box_min_x &&
                  i_vert_c_x <= i_box_min_x) ||
                 (i_vert_a_x >= i_box_max_x && i_vert_b_x >= i_box_max_x &&
                  i_vert_c_x >= i_box_max_x) ||
                 (i_vert_a_y <= i_box_min_y && i_vert_b_y <= i_box_min_y &&
                  i_vert_c_y <= i_box_min_y) ||
                 (i_vert_a_y >= i_box_max_y && i_vert_b_y >= i_box_max_y &&
                  i_vert_c_y >= i_box_max_y);
    end

    logic r2_rej, r3_rej;

    always_ff @(posedge i_clk) begin
        if (en1) r1_rej <= n1_rej;
        if (en2) r2_rej <= r1_rej;
        if (en3) r3_rej <= r2_rej;
    end

    logic r3_sep [3];

    for (genvar e = 0; e < 3; e++) begin : g_edge
        localparam int E1 = (e + 1) % 3;
        localparam int E2 = (e + 2) % 3;

        // stage 1: edge deltas, class, query deltas against the start point
        logic signed [DW-1:0] n1_dx, n1_dy;
        logic signed [DW-1:0] n1_qx [3];
        logic signed [DW-1:0] n1_qy [3];
        t_sgn                 n1_sx [3];
        t_sgn                 n1_sy [3];
        t_cls                 n1_cls;
        t_sgn                 s_dx, s_dy;
        logic                 rise;

        always_comb begin
            n1_dx = DW'(vx[E1]) - DW'(vx[e]);
            n1_dy = DW'(vy[E1]) - DW'(vy[e]);
            s_dx  = sgn_d(n1_dx);
            s_dy  = sgn_d(n1_dy);
            rise  = (s_dx.pos && s_dy.pos) || (s_dx.neg && s_dy.neg);
            if (rise) begin
                n1_cls = CLS_RISE;
            end else if ((s_dx.pos && s_dy.neg) || (s_dx.neg && s_dy.pos)) begin
                n1_cls = CLS_FALL;
            end else if (s_dy.pos || s_dy.neg) begin
                n1_cls = CLS_VERT;
            end else if (s_dx.pos || s_dx.neg) begin
                n1_cls = CLS_HORZ;
            end else begin
                n1_cls = CLS_NONE;
            end
            // third vertex and the two corners chosen by slope
            n1_qx[Q_THIRD] = DW'(vx[E2]) - DW'(vx[e]);
            n1_qy[Q_THIRD] = DW'(vy[E2]) - DW'(vy[e]);
            n1_qx[Q_CRN0]  = DW'(i_box_min_x) - DW'(vx[e]);
            n1_qy[Q_CRN0]  = rise ? DW'(i_box_max_y) - DW'(vy[e])
                                  : DW'(i_box_min_y) - DW'(vy[e]);
            n1_qx[Q_CRN1]  = DW'(i_box_max_x) - DW'(vx[e]);
            n1_qy[Q_CRN1]  = rise ? DW'(i_box_min_y) - DW'(vy[e])
                                  : DW'(i_box_max_y) - DW'(vy[e]);
            for (int k = 0; k < 3; k++) begin
                n1_sx[k] = sgn_d(n1_qx[k]);
                n1_sy[k] = sgn_d(n1_qy[k]);
            end
        end

        logic signed [DW-1:0] r1_dx, r1_dy;
        logic signed [DW-1:0] r1_qx [3];
        logic signed [DW-1:0] r1_qy [3];
        t_sgn                 r1_sx [3];
        t_sgn                 r1_sy [3];
        t_cls                 r1_cls;

        always_ff @(posedge i_clk) begin
            if (en1) begin
                r1_dx  <= n1_dx;
                r1_dy  <= n1_dy;
                r1_qx  <= n1_qx;
                r1_qy  <= n1_qy;
                r1_sx  <= n1_sx;
                r1_sy  <= n1_sy;
                r1_cls <= n1_cls;
            end
        end

        // stage 2: cross products dx*qy and dy*qx
        logic signed [PW-1:0] n2_pa [3];
        logic signed [PW-1:0] n2_pb [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                n2_pa[k] = PW'(r1_dx) * PW'(r1_qy[k]);
                n2_pb[k] = PW'(r1_dy) * PW'(r1_qx[k]);
            end
        end

        logic signed [PW-1:0] r2_pa [3];
        logic signed [PW-1:0] r2_pb [3];
        t_sgn                 r2_sx [3];
        t_sgn                 r2_sy [3];
        t_cls                 r2_cls;

        always_ff @(posedge i_clk) begin
            if (en2) begin
                r2_pa  <= n2_pa;
                r2_pb  <= n2_pb;
                r2_sx  <= r1_sx;
                r2_sy  <= r1_sy;
                r2_cls <= r1_cls;
            end
        end

        // stage 3: orientation signs, axis-aligned edges use plain deltas
        t_sgn                 n3_o [3];
        logic signed [OW-1:0] diff [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                diff[k] = OW'(r2_pa[k]) - OW'(r2_pb[k]);
                case (r2_cls)
                    CLS_VERT: n3_o[k] = r2_sx[k];
                    CLS_HORZ: n3_o[k] = r2_sy[k];
                    default:  n3_o[k] = sgn_o(diff[k]);
                endcase
            end
        end

        t_sgn r3_o [3];
        t_cls r3_cls;

        always_ff @(posedge i_clk) begin
            if (en3) begin
                r3_o   <= n3_o;
                r3_cls <= r2_cls;
            end
        end

        assign r3_sep[e] = edge_sep(r3_cls, r3_o[Q_THIRD], r3_o[Q_CRN0], r3_o[Q_CRN1]);
    end

    // stage 4: final verdict
    always_ff @(posedge i_clk) begin
        if (en4) begin
            o_overlap <= !(r3_rej || r3_sep[0] || r3_sep[1] || r3_sep[2]);
        end
    end

endmodule

`default_nettype wire
